// ----- design/ccra_pkg.sv -----
// Shared types and codes for the contiguous cell run allocator.
// Used by ccra_ctrl, ccra_datapath and the top level; depends on nothing.
package ccra_pkg;

    // Request kinds carried on the input tuser
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    // Result status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_NO_SLOT = 3'd1;
    localparam logic [2:0] ST_NO_RUN  = 3'd2;
    localparam logic [2:0] ST_ZERO    = 3'd3;
    localparam logic [2:0] ST_IDLE    = 3'd4;

    // Beat widths on the stream ports
    localparam int unsigned IN_DATA_W  = 16;
    localparam int unsigned OUT_DATA_W = 16;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic       load;       // capture the input beat
        logic       len_load;   // register rows * columns
        logic       scan_init;  // restart the bitmap scan
        logic       scan_step;  // examine one cell
        logic       mark;       // claim the found run and the idle slot
        logic       clear;      // release the named slot's cells
        logic       emit;       // load the result register
        logic [2:0] code;       // status of the result being loaded
    } t_ctl_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic kind;        // captured request kind
        logic len_zero;    // requested length is zero
        logic slot_avail;  // some slot is idle
        logic us_busy;     // named slot is in range and busy
        logic scan_hit;    // current cell completes a full run
        logic scan_last;   // current cell is the last in the bitmap
        logic out_free;    // result register can take a beat
    } t_dp_status;

endpackage

// ----- design/ccra_datapath.sv -----
// Datapath of the allocator: bitmap, slot table, scan counters, result register.
// Driven by ccra_ctrl through ccra_pkg::t_ctl_cmd; depends on ccra_pkg.
module ccra_datapath #(
    parameter int CELL_COUNT = 64,
    parameter int SLOT_COUNT = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic [ccra_pkg::IN_DATA_W-1:0]       i_s_tdata,
    input  logic                                 i_s_tuser,
    input  ccra_pkg::t_ctl_cmd                   i_cmd,
    output ccra_pkg::t_dp_status                 o_status,
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    output logic [ccra_pkg::OUT_DATA_W-1:0]      o_m_tdata
);
    import ccra_pkg::*;

    localparam int CELL_W = $clog2(CELL_COUNT);
    localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    // Captured request
    logic              r_kind;
    logic [3:0]        r_rows;
    logic [3:0]        r_cols;
    logic [2:0]        r_us;
    logic [7:0]        r_len;

    // Allocation state
    logic [CELL_COUNT-1:0] r_cell_used;
    logic [SLOT_COUNT-1:0] r_slot_busy;
    logic [CELL_W-1:0]     r_slot_start  [SLOT_COUNT];
    logic [7:0]            r_slot_length [SLOT_COUNT];

    // Scan state
    logic [CELL_W-1:0] r_cnt;
    logic [7:0]        r_run;
    logic [CELL_W-1:0] r_begin;
    logic [SLOT_W-1:0] r_grant;

    // Result register
    logic        r_out_valid;
    logic [2:0]  r_out_status;
    logic [2:0]  r_out_slot;
    logic [5:0]  r_out_cell;

    logic [SLOT_W-1:0]     free_idx;
    logic                  slot_avail;
    logic [7:0]            us_ext;
    logic [SLOT_W-1:0]     us_idx;
    logic                  us_valid;
    logic                  us_busy;
    logic                  cell_free;
    logic [8:0]            run_inc;
    logic                  scan_hit;
    logic [CELL_W-1:0]     begin_sel;
    logic [8:0]            rng_start;
    logic [8:0]            rng_end;
    logic [CELL_COUNT-1:0] rng_mask;
    logic [7:0]            grant_ext;
    logic [15:0]           begin_ext;

    // Pick the lowest idle slot
    always_comb begin
        free_idx = '0;
        for (int s = SLOT_COUNT - 1; s >= 0; s--) begin
            if (!r_slot_busy[s]) begin
                free_idx = SLOT_W'(s);
            end
        end
    end
    assign slot_avail = ~&r_slot_busy;

    // Check the slot named by a free request
    assign us_ext   = {5'b0, r_us};
    assign us_idx   = us_ext[SLOT_W-1:0];
    assign us_valid = ({3'b0, r_us} < 6'(SLOT_COUNT));
    assign us_busy  = us_valid && r_slot_busy[us_idx];

    // One scan step: extend or break the current free run
    assign cell_free = !r_cell_used[r_cnt];
    assign run_inc   = {1'b0, r_run} + 9'd1;
    assign scan_hit  = cell_free && (run_inc >= {1'b0, r_len});
    assign begin_sel = (r_run == 8'd0) ? r_cnt : r_begin;

    // Cell range touched by a mark or a clear; stops at the bitmap end
    assign rng_start = (r_kind == KIND_ALLOC) ? 9'(r_begin) : 9'(r_slot_start[us_idx]);
    assign rng_end   = rng_start + ((r_kind == KIND_ALLOC) ? {1'b0, r_len}
                                                           : {1'b0, r_slot_length[us_idx]});
    always_comb begin
        for (int c = 0; c < CELL_COUNT; c++) begin
            rng_mask[c] = (9'(c) >= rng_start) && (9'(c) < rng_end);
        end
    end

    // Capture the request and its length
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_s_tuser;
            r_rows <= i_s_tdata[3:0];
            r_cols <= i_s_tdata[7:4];
            r_us   <= i_s_tdata[10:8];
        end
        if (i_cmd.len_load) begin
            r_len <= r_rows * r_cols;
        end
    end

    // Advance the first-fit scan
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_init) begin
            r_cnt <= '0;
            r_run <= '0;
        end else if (i_cmd.scan_step) begin
            r_cnt <= r_cnt + 1'b1;
            if (cell_free) begin
                r_run   <= run_inc[7:0];
                r_begin <= begin_sel;
            end else begin
                r_run <= '0;
            end
        end
    end

    // Update the bitmap and slot busy flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_used <= '0;
            r_slot_busy <= '0;
        end else if (i_cmd.mark) begin
            r_cell_used           <= r_cell_used | rng_mask;
            r_slot_busy[free_idx] <= 1'b1;
        end else if (i_cmd.clear) begin
            r_cell_used         <= r_cell_used & ~rng_mask;
            r_slot_busy[us_idx] <= 1'b0;
        end
    end

    // Record the run in the granted slot
    always_ff @(posedge i_clk) begin
        if (i_cmd.mark) begin
            r_slot_start[free_idx]  <= r_begin;
            r_slot_length[free_idx] <= r_len;
            r_grant                 <= free_idx;
        end
    end

    // Result register: load on emit, drop once the beat is taken
    assign grant_ext = 8'(r_grant);
    assign begin_ext = 16'(r_begin);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_status <= i_cmd.code;
            if (r_kind == KIND_FREE) begin
                r_out_slot <= r_us;
                r_out_cell <= '0;
            end else if (i_cmd.code == ST_OK) begin
                r_out_slot <= grant_ext[2:0];
                r_out_cell <= begin_ext[5:0];
            end else begin
                r_out_slot <= '0;
                r_out_cell <= '0;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'b0, r_out_cell, r_out_slot, r_out_status};

    // Status toward the controller
    assign o_status.kind       = r_kind;
    assign o_status.len_zero   = (r_len == 8'd0);
    assign o_status.slot_avail = slot_avail;
    assign o_status.us_busy    = us_busy;
    assign o_status.scan_hit   = scan_hit;
    assign o_status.scan_last  = (r_cnt == CELL_W'(CELL_COUNT - 1));
    assign o_status.out_free   = !r_out_valid || i_m_tready;

    // A claimed run lies entirely on free cells
    a_mark_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.mark |-> ((r_cell_used & rng_mask) == '0))
        else $error("run claimed over used cells");

    // A released slot owns used cells only
    a_clear_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clear |-> ((r_cell_used & rng_mask) == rng_mask))
        else $error("slot release over free cells");

    // A mark always has an idle slot to take
    a_mark_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.mark |-> !r_slot_busy[free_idx])
        else $error("mark with no idle slot");

endmodule

// ----- design/ccra_ctrl.sv -----
// Controller of the allocator: sequences capture, decision, scan, update, result.
// Talks to ccra_datapath through ccra_pkg command and status structs.
module ccra_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  ccra_pkg::t_dp_status  i_status,
    output ccra_pkg::t_ctl_cmd    o_cmd
);
    import ccra_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_LEN    = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_MARK   = 3'd4;
    localparam logic [2:0] S_EMIT   = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic [2:0] r_code;
    logic [2:0] n_code;

    assign o_s_tready = (r_state == S_IDLE);

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_code  = r_code;
        o_cmd   = '0;
        o_cmd.code = r_code;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_LEN;
                end
            end
            S_LEN: begin
                o_cmd.len_load = 1'b1;
                n_state        = S_DECIDE;
            end
            S_DECIDE: begin
                if (i_status.kind == KIND_FREE) begin
                    if (i_status.us_busy) begin
                        o_cmd.clear = 1'b1;
                        n_code      = ST_OK;
                    end else begin
                        n_code = ST_IDLE;
                    end
                    n_state = S_EMIT;
                end else if (i_status.len_zero) begin
                    n_code  = ST_ZERO;
                    n_state = S_EMIT;
                end else if (!i_status.slot_avail) begin
                    n_code  = ST_NO_SLOT;
                    n_state = S_EMIT;
                end else begin
                    o_cmd.scan_init = 1'b1;
                    n_state         = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_status.scan_hit) begin
                    n_state = S_MARK;
                end else if (i_status.scan_last) begin
                    n_code  = ST_NO_RUN;
                    n_state = S_EMIT;
                end
            end
            S_MARK: begin
                o_cmd.mark = 1'b1;
                n_code     = ST_OK;
                n_state    = S_EMIT;
            end
            S_EMIT: begin
                // Hold the result until the output register is free
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_code  <= ST_OK;
        end else begin
            r_state <= n_state;
            r_code  <= n_code;
        end
    end

    // A result is loaded only when the output register can take it
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_status.out_free)
        else $error("result loaded over a pending beat");

    // The scan runs for allocate requests only
    a_scan_alloc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (i_status.kind == KIND_ALLOC))
        else $error("scan during a free request");

    // Without an accepted beat the controller stays idle
    a_idle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && !i_s_tvalid) |=> (r_state == S_IDLE))
        else $error("controller left idle without a request");

endmodule

// ----- design/contiguous_cell_run_allocator.sv -----
// Top level of the contiguous cell run allocator.
// Joins ccra_ctrl and ccra_datapath; depends on ccra_pkg.
//
// Usage:
//   Slave channel (i_s_*) takes one request per beat. tuser is the kind
//   (0 allocate, 1 free). tdata carries rows, columns and the slot to free.
//   Master channel (o_m_*) returns exactly one result beat per request:
//   status, granted slot and first cell of the allocated run.
//   Sequence: a free passes the LEN, DECIDE and EMIT states from accept to
//   result valid, as does an allocate that fails before the scan. One that
//   scans examines one cell per cycle in SCAN, then goes through MARK when
//   a cell completes a run, or straight to EMIT at the last cell.
//   One request is in flight at a time; the next is accepted the cycle
//   after the result is loaded.
//   Reset (i_rst_n low, synchronous) frees every cell, idles every slot and
//   empties the result register.
//   When the receiver stalls, the result beat holds in the output register;
//   one more request may be accepted and processed, then the block waits
//   with its result until the register drains.
module contiguous_cell_run_allocator #(
    parameter int CELL_COUNT = 64,
    parameter int SLOT_COUNT = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    // tdata: [3:0] rows, [7:4] columns, [10:8] user_slot, [15:11] zero
    input  logic [ccra_pkg::IN_DATA_W-1:0]       i_s_tdata,
    // tuser: [0] kind
    input  logic                                 i_s_tuser,
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    // tdata: [2:0] status, [5:3] granted_slot, [11:6] first_cell, [15:12] zero
    output logic [ccra_pkg::OUT_DATA_W-1:0]      o_m_tdata
);
    import ccra_pkg::*;

    t_ctl_cmd   cmd;
    t_dp_status status;

    ccra_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    ccra_datapath #(
        .CELL_COUNT (CELL_COUNT),
        .SLOT_COUNT (SLOT_COUNT)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

endmodule

// ----- bench/tb.sv -----
// Self-checking bench for contiguous_cell_run_allocator: a local first-fit predictor
// tracks cells and slots, and results are compared beat by beat in order.
// Depends on ccra_pkg and the design top level only.
module tb;
    import ccra_pkg::*;

    localparam int CELLS        = 64;
    localparam int SLOTS        = 8;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 100;

    // One expected result beat
    typedef struct packed {
        logic [2:0] status;
        logic [2:0] slot;
        logic [5:0] first_cell;
    } t_grant;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    // tdata: [3:0] rows, [7:4] columns, [10:8] user_slot, [15:11] zero
    logic [15:0] i_s_tdata;
    // tuser: [0] kind
    logic        i_s_tuser;
    logic        o_m_tvalid;
    logic        i_m_tready;
    // tdata: [2:0] status, [5:3] granted_slot, [11:6] first_cell, [15:12] zero
    logic [15:0] o_m_tdata;

    // Predictor copy of the allocator state
    logic        cell_used_q [CELLS];
    logic        slot_busy_q [SLOTS];
    logic [5:0]  slot_start_q [SLOTS];
    logic [7:0]  slot_len_q [SLOTS];

    t_grant      expected_grants[$];
    int          error_count;
    int          sent_count;
    int          checked_count;
    int          cycle_count;
    int          status_count [5];
    bit          tx_idle_en;
    bit          rx_idle_en;

    contiguous_cell_run_allocator #(
        .CELL_COUNT(CELLS),
        .SLOT_COUNT(SLOTS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // Free-running clock, period 20
    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Compute the result of one request and update the tracked state
    function automatic t_grant predict_grant(input logic kind, input logic [3:0] rows,
                                             input logic [3:0] cols,
                                             input logic [2:0] user_slot);
        t_grant g;
        int     len;
        int     s;
        int     c;
        int     run_len;
        int     run_base;
        bit     slot_found;
        bit     hit;
        g = '0;
        if (kind == KIND_ALLOC) begin
            len = int'(rows) * int'(cols);
            if (len == 0) begin
                g.status = ST_ZERO;
            end else begin
                slot_found = 1'b0;
                s = 0;
                for (int i = 0; i < SLOTS; i++) begin
                    if (!slot_found && !slot_busy_q[i]) begin
                        s = i;
                        slot_found = 1'b1;
                    end
                end
                if (!slot_found) begin
                    g.status = ST_NO_SLOT;
                end else begin
                    // First-fit scan; a run cut short at the end does not count
                    run_len = 0;
                    run_base = 0;
                    hit = 1'b0;
                    for (c = 0; c < CELLS && !hit; c++) begin
                        if (cell_used_q[c]) begin
                            run_len = 0;
                        end else begin
                            if (run_len == 0) run_base = c;
                            run_len++;
                            if (run_len >= len) hit = 1'b1;
                        end
                    end
                    if (!hit) begin
                        g.status = ST_NO_RUN;
                    end else begin
                        for (c = run_base; c < run_base + len && c < CELLS; c++)
                            cell_used_q[c] = 1'b1;
                        slot_busy_q[s]  = 1'b1;
                        slot_start_q[s] = run_base[5:0];
                        slot_len_q[s]   = len[7:0];
                        g.status     = ST_OK;
                        g.slot       = s[2:0];
                        g.first_cell = run_base[5:0];
                    end
                end
            end
        end else begin
            g.slot = user_slot;
            if (int'(user_slot) >= SLOTS || !slot_busy_q[user_slot]) begin
                g.status = ST_IDLE;
            end else begin
                // Release the slot's cells, stopping at the bitmap end
                for (c = int'(slot_start_q[user_slot]);
                     c < int'(slot_start_q[user_slot]) + int'(slot_len_q[user_slot]) &&
                     c < CELLS; c++)
                    cell_used_q[c] = 1'b0;
                slot_busy_q[user_slot] = 1'b0;
                g.status = ST_OK;
            end
        end
        return g;
    endfunction

    // Print one mismatch line and count it
    task automatic report_mismatch(input string what, input int got_val, input int want_val);
        $display("MISMATCH %s: got %0d expected %0d (cycle %0d)",
                 what, got_val, want_val, cycle_count);
        error_count++;
    endtask

    // Drive one request beat, hold it until accepted, then record its expected result
    task automatic send_request(input logic kind, input logic [3:0] rows,
                                input logic [3:0] cols, input logic [2:0] user_slot);
        t_grant g;
        int     gap;
        @(negedge i_clk);
        i_s_tvalid = 1'b1;
        i_s_tuser  = kind;
        i_s_tdata  = {5'b0, user_slot, cols, rows};
        do @(posedge i_clk); while (!o_s_tready);
        g = predict_grant(kind, rows, cols, user_slot);
        expected_grants.push_back(g);
        sent_count++;
        status_count[g.status]++;
        // Insert a random sender gap
        if (tx_idle_en && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 16);
            @(negedge i_clk);
            i_s_tvalid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // Drop valid and hold until every expected beat has arrived
    task automatic wait_for_drain();
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        while (expected_grants.size() != 0) @(posedge i_clk);
    endtask

    // Mostly well-formed traffic: modest allocations and frees of busy slots
    task automatic send_random_request();
        logic       kind;
        logic [3:0] rows;
        logic [3:0] cols;
        logic [2:0] us;
        int         pick;
        int         busy_list[$];
        rows = 4'($urandom_range(0, 15));
        cols = 4'($urandom_range(0, 15));
        us   = 3'($urandom_range(0, 7));
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            kind = KIND_ALLOC;
            if (pick >= 8) begin
                rows = 4'($urandom_range(1, 4));
                cols = 4'($urandom_range(1, 6));
            end
        end else begin
            kind = KIND_FREE;
            for (int i = 0; i < SLOTS; i++)
                if (slot_busy_q[i]) busy_list.push_back(i);
            if (busy_list.size() > 0 && $urandom_range(0, 9) != 0)
                us = 3'(busy_list[$urandom_range(0, busy_list.size() - 1)]);
        end
        send_request(kind, rows, cols, us);
    endtask

    // Extremes of size, full bitmap, full slot table, idle frees, tail runs
    task automatic test_directed_cases();
        send_request(KIND_ALLOC, 4'd8, 4'd8, 3'd0);    // whole bitmap
        send_request(KIND_ALLOC, 4'd1, 4'd1, 3'd7);    // bitmap full
        send_request(KIND_ALLOC, 4'd15, 4'd15, 3'd0);  // longer than the bitmap
        send_request(KIND_ALLOC, 4'd0, 4'd15, 3'd0);   // zero rows
        send_request(KIND_ALLOC, 4'd15, 4'd0, 3'd0);   // zero columns
        send_request(KIND_FREE, 4'd15, 4'd15, 3'd7);   // free an idle slot
        send_request(KIND_FREE, 4'd0, 4'd0, 3'd0);
        send_request(KIND_ALLOC, 4'd6, 4'd10, 3'd0);   // leave a 4-cell tail
        send_request(KIND_ALLOC, 4'd1, 4'd5, 3'd0);    // tail too short
        send_request(KIND_ALLOC, 4'd2, 4'd2, 3'd0);    // fits the tail exactly
        send_request(KIND_FREE, 4'd0, 4'd0, 3'd0);
        send_request(KIND_ALLOC, 4'd1, 4'd3, 3'd0);    // first fit from cell 0
        send_request(KIND_ALLOC, 4'd3, 4'd1, 3'd0);
        for (int i = 0; i < 5; i++)
            send_request(KIND_ALLOC, 4'd1, 4'd1, 3'd0);
        send_request(KIND_ALLOC, 4'd1, 4'd1, 3'd0);    // slot table full
        send_request(KIND_ALLOC, 4'd0, 4'd0, 3'd0);    // zero size wins over full table
        for (int i = 0; i < SLOTS; i++)
            send_request(KIND_FREE, 4'd0, 4'd0, 3'(i));
        wait_for_drain();
    endtask

    // Random traffic with idling on both sides
    task automatic test_random_traffic(input int count);
        repeat (count) send_random_request();
    endtask

    // Bursts followed by a full drain before the sender resumes
    task automatic test_drain_pauses();
        repeat (3) begin
            repeat (40) send_random_request();
            wait_for_drain();
        end
    endtask

    // Back-to-back traffic with no idling at all
    task automatic test_steady_stream(input int count);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        repeat (count) send_random_request();
    endtask

    // Receiver: ready by default, stalls in random bursts
    initial begin
        i_m_tready = 1'b1;
        forever begin
            @(negedge i_clk);
            if (rx_idle_en && $urandom_range(0, 7) == 0) begin
                i_m_tready = 1'b0;
                repeat ($urandom_range(1, 16)) @(negedge i_clk);
                i_m_tready = 1'b1;
            end
        end
    end

    // Compare each accepted result beat with the oldest expectation
    always @(posedge i_clk) begin
        t_grant want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            checked_count++;
            if (expected_grants.size() == 0) begin
                report_mismatch("result with none expected", int'(o_m_tdata), 0);
            end else begin
                want = expected_grants.pop_front();
                if (o_m_tdata[2:0] != want.status)
                    report_mismatch("status", o_m_tdata[2:0], want.status);
                if (o_m_tdata[5:3] != want.slot)
                    report_mismatch("granted_slot", o_m_tdata[5:3], want.slot);
                if (o_m_tdata[11:6] != want.first_cell)
                    report_mismatch("first_cell", o_m_tdata[11:6], want.first_cell);
                if (o_m_tdata[15:12] != 4'd0)
                    report_mismatch("padding", o_m_tdata[15:12], 0);
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_grants.size());
            $display("FAILURE");
            $finish;
        end
    end

    // Reset, run the tests in turn, report
    initial begin
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tuser  = KIND_ALLOC;
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        error_count = 0;
        sent_count = 0;
        checked_count = 0;
        cycle_count = 0;
        for (int i = 0; i < 5; i++) status_count[i] = 0;
        for (int i = 0; i < CELLS; i++) cell_used_q[i] = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
            slot_busy_q[i]  = 1'b0;
            slot_start_q[i] = '0;
            slot_len_q[i]   = '0;
        end
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_cases();
        test_random_traffic(1400);
        test_drain_pauses();
        test_steady_stream(450);

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d requests, %0d results checked, %0d mismatches",
                 sent_count, checked_count, error_count);
        $display("outcomes: %0d ok, %0d no slot, %0d no run, %0d zero size, %0d slot idle",
                 status_count[ST_OK], status_count[ST_NO_SLOT], status_count[ST_NO_RUN],
                 status_count[ST_ZERO], status_count[ST_IDLE]);
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ----- files.f -----
design/ccra_pkg.sv
design/ccra_datapath.sv
design/ccra_ctrl.sv
design/contiguous_cell_run_allocator.sv
bench/tb.sv
